// ----- src/bvap_pkg.sv -----
package bvap_pkg;

  localparam int unsigned MvW       = 16;
  localparam int unsigned PctW      = 7;
  localparam int unsigned RawW      = 10;
  localparam int unsigned ResW      = 20;
  localparam int unsigned RatioW    = ResW + 1;
  localparam int unsigned DivNumW   = MvW + RatioW;
  localparam int unsigned DivDenW   = ResW;
  localparam int unsigned DivCntW   = $clog2(DivNumW + 1);
  localparam int unsigned AdcProdW  = RawW + MvW;
  localparam int unsigned PctProdW  = MvW + 7;

  localparam logic [RawW:0]     AdcMaxCode = (RawW + 1)'(1023);
  localparam logic [MvW-1:0]    MvLimit    = MvW'(65535);
  localparam logic [PctW-1:0]   PctFull    = PctW'(100);
  localparam logic [RatioW-1:0] PctScale   = RatioW'(100);

  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = ResW;

  localparam logic [CfgAddrW-1:0] CfgEnabled = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgVref    = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgDivTop  = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgDivBot  = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgEmpty   = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgFull    = 3'd5;

  typedef struct packed {
    logic               start;
    logic [DivCntW-1:0] iters;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

endpackage

// ----- src/battery_voltage_average_percent_unit.sv -----
// Battery gauge: each item is one 10-bit ADC sample, scaled to millivolts through vref and
// the resistor divider (saturating at 65535 mV), pushed into a ring of the last
// WINDOW_SAMPLES readings, and answered with the floor mean of the filled entries plus a
// 0..100 charge percent between empty_mv and full_mv. The divisions by the divider bottom,
// the filled count and the threshold span run on one shared bit-serial divider (one
// quotient bit a cycle), the division by 1023 is folded combinationally with shifts and
// adds, and all products use one shared 16x21 multiplier; the window sum walks the sample
// RAM entry by entry, a read state and then an accumulate state for each. An item skips
// the percent division when the percent clamps, and skips the divider-ratio scaling when
// the divider bottom is zero; a disabled item is not stored and goes straight to the
// output with zeros. A result waits in S_OUT until the output register is free or
// out_ready_i is high. The block takes one item at a time; a finished result waits
// in the output register while the next item is accepted.
module battery_voltage_average_percent_unit import bvap_pkg::*; #(
  parameter int unsigned WINDOW_SAMPLES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [RawW-1:0]     raw_sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [MvW-1:0]      battery_mv_o,
  output logic [PctW-1:0]     charge_percent_o
);

  localparam int unsigned IdxW   = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int unsigned CntW   = $clog2(WINDOW_SAMPLES + 1);
  localparam int unsigned SumW   = MvW + $clog2(WINDOW_SAMPLES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WINDOW_SAMPLES - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(WINDOW_SAMPLES);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000_0000_0000_0001,
    S_MUL_ADC  = 15'b000_0000_0000_0010,
    S_DIV_ADC  = 15'b000_0000_0000_0100,
    S_MUL_BAT  = 15'b000_0000_0000_1000,
    S_DIV_BAT  = 15'b000_0000_0001_0000,
    S_WAIT_BAT = 15'b000_0000_0010_0000,
    S_STORE    = 15'b000_0000_0100_0000,
    S_SUM_RD   = 15'b000_0000_1000_0000,
    S_SUM_ACC  = 15'b000_0001_0000_0000,
    S_DIV_MEAN = 15'b000_0010_0000_0000,
    S_WAIT_MEAN= 15'b000_0100_0000_0000,
    S_PCT      = 15'b000_1000_0000_0000,
    S_DIV_PCT  = 15'b001_0000_0000_0000,
    S_WAIT_PCT = 15'b010_0000_0000_0000,
    S_OUT      = 15'b100_0000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic            enabled_q;
  logic [MvW-1:0]  vref_q;
  logic [ResW-1:0] top_q;
  logic [ResW-1:0] bot_q;
  logic [MvW-1:0]  empty_q;
  logic [MvW-1:0]  full_q;

  logic [IdxW-1:0] widx_q, widx_d;
  logic            ring_full_q, ring_full_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] sum_q, sum_d;

  logic [RawW-1:0]    raw_q, raw_d;
  logic [MvW-1:0]     val_q, val_d;
  logic [PctW-1:0]    pct_q, pct_d;
  logic [DivNumW-1:0] prod_q, prod_d;
  logic [MvW-1:0]     mul_a;
  logic [RatioW-1:0]  mul_b;
  logic               mul_en;

  logic [MvW:0]    fold_y;
  logic [RawW:0]   fold_z;
  logic [MvW-1:0]  adc_mv;

  logic            out_valid_q, out_valid_d;
  logic [MvW-1:0]  out_mv_q, out_mv_d;
  logic [PctW-1:0] out_pct_q, out_pct_d;
  logic            out_free;

  logic            ram_we;
  logic [MvW-1:0]  ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  bvap_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bvap_ram #(
    .WIDTH (MvW),
    .DEPTH (WINDOW_SAMPLES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (widx_q),
    .wdata_i (val_q),
    .raddr_i (ridx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      vref_q    <= MvW'(3300);
      top_q     <= ResW'(220);
      bot_q     <= ResW'(100);
      empty_q   <= MvW'(3300);
      full_q    <= MvW'(4200);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgEnabled: enabled_q <= cfg_wdata_i[0];
        CfgVref:    vref_q    <= cfg_wdata_i[MvW-1:0];
        CfgDivTop:  top_q     <= cfg_wdata_i;
        CfgDivBot:  bot_q     <= cfg_wdata_i;
        CfgEmpty:   empty_q   <= cfg_wdata_i[MvW-1:0];
        CfgFull:    full_q    <= cfg_wdata_i[MvW-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_en = 1'b0;
    mul_a  = val_q;
    mul_b  = PctScale;
    unique case (state_q)
      S_MUL_ADC: begin
        mul_en = 1'b1;
        mul_a  = vref_q;
        mul_b  = RatioW'(raw_q);
      end
      S_MUL_BAT: begin
        mul_en = 1'b1;
        mul_b  = RatioW'(top_q) + RatioW'(bot_q);
      end
      S_PCT: begin
        mul_en = 1'b1;
        mul_a  = val_q - empty_q;
      end
      default: ;
    endcase
    prod_d = mul_en ? DivNumW'(mul_a) * DivNumW'(mul_b) : prod_q;
  end

  // divide by 1023: x = 1024*a + b = 1023*a + (a + b), folded twice
  always_comb begin
    fold_y = {1'b0, prod_q[AdcProdW-1:RawW]} + (MvW + 1)'(prod_q[RawW-1:0]);
    fold_z = (RawW + 1)'(fold_y[MvW:RawW]) + {1'b0, fold_y[RawW-1:0]};
    adc_mv = prod_q[AdcProdW-1:RawW] + MvW'(fold_y[MvW:RawW])
           + MvW'(fold_z >= AdcMaxCode);
  end

  // shared divider request, dividend left-aligned to its bit count
  always_comb begin
    div_req.start = 1'b0;
    div_req.iters = DivCntW'(DivNumW);
    div_req.num   = prod_q;
    div_req.den   = bot_q;
    unique case (state_q)
      S_DIV_BAT: begin
        div_req.start = 1'b1;
      end
      S_DIV_MEAN: begin
        div_req.start = 1'b1;
        div_req.iters = DivCntW'(SumW);
        div_req.num   = DivNumW'(sum_q) << (DivNumW - SumW);
        div_req.den   = DivDenW'(count_q);
      end
      S_DIV_PCT: begin
        div_req.start = 1'b1;
        div_req.iters = DivCntW'(PctProdW);
        div_req.num   = DivNumW'(prod_q[PctProdW-1:0]) << (DivNumW - PctProdW);
        div_req.den   = DivDenW'(full_q - empty_q);
      end
      default: ;
    endcase
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    raw_d       = raw_q;
    val_d       = val_q;
    pct_d       = pct_q;
    widx_d      = widx_q;
    ring_full_d = ring_full_q;
    ridx_d      = ridx_q;
    count_d     = count_q;
    sum_d       = sum_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_mv_d    = out_mv_q;
    out_pct_d   = out_pct_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          raw_d = raw_sample_i;
          if (enabled_q) begin
            state_d = S_MUL_ADC;
          end else begin
            val_d   = '0;
            pct_d   = '0;
            state_d = S_OUT;
          end
        end
      end
      S_MUL_ADC: state_d = S_DIV_ADC;
      S_DIV_ADC: begin
        if (bot_q == '0) begin
          val_d   = MvLimit;
          state_d = S_STORE;
        end else begin
          val_d   = adc_mv;
          state_d = S_MUL_BAT;
        end
      end
      S_MUL_BAT: state_d = S_DIV_BAT;
      S_DIV_BAT: state_d = S_WAIT_BAT;
      S_WAIT_BAT: begin
        if (div_rsp.done) begin
          val_d   = (|div_rsp.quo[DivNumW-1:MvW]) ? MvLimit : div_rsp.quo[MvW-1:0];
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        ram_we = 1'b1;
        ridx_d = '0;
        sum_d  = '0;
        if (widx_q == LastIdx) begin
          widx_d      = '0;
          ring_full_d = 1'b1;
          count_d     = FullCnt;
        end else begin
          widx_d  = widx_q + IdxW'(1);
          count_d = ring_full_q ? FullCnt : CntW'(widx_q) + CntW'(1);
        end
        state_d = S_SUM_RD;
      end
      S_SUM_RD: state_d = S_SUM_ACC;
      S_SUM_ACC: begin
        sum_d = sum_q + SumW'(ram_rdata);
        if (CntW'(ridx_q) + CntW'(1) == count_q) begin
          state_d = S_DIV_MEAN;
        end else begin
          ridx_d  = ridx_q + IdxW'(1);
          state_d = S_SUM_RD;
        end
      end
      S_DIV_MEAN: state_d = S_WAIT_MEAN;
      S_WAIT_MEAN: begin
        if (div_rsp.done) begin
          val_d   = div_rsp.quo[MvW-1:0];
          state_d = S_PCT;
        end
      end
      S_PCT: begin
        if (val_q <= empty_q) begin
          pct_d   = '0;
          state_d = S_OUT;
        end else if (val_q >= full_q) begin
          pct_d   = PctFull;
          state_d = S_OUT;
        end else begin
          state_d = S_DIV_PCT;
        end
      end
      S_DIV_PCT: state_d = S_WAIT_PCT;
      S_WAIT_PCT: begin
        if (div_rsp.done) begin
          pct_d   = div_rsp.quo[PctW-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_mv_d    = val_q;
          out_pct_d   = pct_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      widx_q      <= '0;
      ring_full_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      ring_full_q <= ring_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q     <= raw_d;
    val_q     <= val_d;
    pct_q     <= pct_d;
    prod_q    <= prod_d;
    ridx_q    <= ridx_d;
    count_q   <= count_d;
    sum_q     <= sum_d;
    out_mv_q  <= out_mv_d;
    out_pct_q <= out_pct_d;
  end

  assign out_valid_o      = out_valid_q;
  assign battery_mv_o     = out_mv_q;
  assign charge_percent_o = out_pct_q;

endmodule

// ----- src/bvap_ram.sv -----
module bvap_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bvap_div.sv -----
module bvap_div import bvap_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic [DivDenW:0]   diff;
  logic               ge;

  always_comb begin
    trial = {rem_q, quo_q[DivNumW-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      cnt_d = req_i.iters;
      quo_d = req_i.num;
      rem_d = '0;
      den_d = req_i.den;
    end else if (cnt_q != '0) begin
      // one quotient bit per cycle
      cnt_d  = cnt_q - DivCntW'(1);
      done_d = (cnt_q == DivCntW'(1));
      rem_d  = ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_d  = {quo_q[DivNumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule
